### src/dcpr_pkg.sv
// Shared types and constants for the depth-to-colour pixel reprojection block.
// Holds the payload structs, register indexes, reset values and extrinsics.
// Depends on nothing; the top level and the testbench use it.
`default_nettype none

package dcpr_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_W     = 20;
    localparam int IDX_W     = 3;

    localparam int COLOR_WIDTH_DEF  = 1280;
    localparam int COLOR_HEIGHT_DEF = 720;

    typedef enum logic [IDX_W-1:0] {
        REG_DEPTH_FX = 3'd0,
        REG_DEPTH_FY = 3'd1,
        REG_DEPTH_CX = 3'd2,
        REG_DEPTH_CY = 3'd3,
        REG_COLOR_FX = 3'd4,
        REG_COLOR_FY = 3'd5,
        REG_COLOR_CX = 3'd6,
        REG_COLOR_CY = 3'd7
    } cfg_idx_t;

    localparam logic [REG_W-1:0] CFG_RESET [REG_COUNT] = '{
        20'd163840, 20'd163840, 20'd163840, 20'd92160,
        20'd163840, 20'd163840, 20'd163840, 20'd92160
    };

    // Rotation in signed Q1.22, one row per output axis.
    localparam logic signed [23:0] ROT [3][3] = '{
        '{ 24'sd4194296,  24'sd4383,    -24'sd7416   },
        '{ -24'sd4383,    24'sd4194300, -24'sd323    },
        '{ 24'sd7416,     24'sd327,      24'sd4194296 }
    };

    // Translation in signed Q5.6 millimetres.
    localparam logic signed [11:0] TRANS [3] = '{ -12'sd886, -12'sd14, -12'sd131 };

    typedef struct packed {
        logic [10:0] src_col;
        logic [10:0] src_row;
        logic [15:0] depth_mm;
    } pix_t;

    typedef struct packed {
        logic [10:0] dst_col;
        logic [9:0]  dst_row;
        logic [15:0] dst_depth;
    } res_t;

endpackage

`default_nettype wire

### src/dcpr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Flags an overflow when the quotient does not fit in Q_W bits.
// Depends on no package; instantiated by the reprojection top level.
`default_nettype none

module dcpr_div #(
    parameter int NUM_W  = 44,
    parameter int DEN_W  = 20,
    parameter int Q_W    = 36,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);

    logic [Q_W:0]        vld_reg;
    logic [DEN_W-1:0]    rem_reg  [Q_W];
    logic [DEN_W-1:0]    den_reg  [Q_W];
    logic [Q_W-1:0]      lo_reg   [Q_W+1];
    logic                ovf_reg  [Q_W+1];
    logic [SIDE_W-1:0]   side_reg [Q_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-1:0], in_valid};
        end
    end

    // The high numerator bits start as the partial remainder; if they already
    // reach the divisor the quotient cannot fit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num[NUM_W-1:Q_W]);
            den_reg[0]  <= den;
            lo_reg[0]   <= num[Q_W-1:0];
            ovf_reg[0]  <= (DEN_W'(num[NUM_W-1:Q_W]) >= den);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[k], lo_reg[k][Q_W-1]};
            diff  = trial - {1'b0, den_reg[k]};
            ge    = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[k+1]   <= {lo_reg[k][Q_W-2:0], ge};
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quo       = lo_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

`default_nettype wire

### src/depth_to_color_pixel_reprojection.sv
// Depth-to-colour pixel reprojection, top level with pipeline and output buffer.
// Depends on dcpr_pkg for types and constants and on dcpr_div for both divisions.
//
// One depth pixel is taken per clock unless the pipeline stalls, and yields either
// one colour-image target pixel with its depth or nothing (zero depth, zero
// depth focal length, point behind the colour camera, or target outside the
// frame). The pipeline holds about 72 pixels in flight: two stages of
// back-projection set-up, a 37-stage divider by the depth focal length, eight
// stages of rotation, translation and projection products, a 23-stage divider
// by the point depth, and two stages of rounding and frame test. Results leave
// through an output register backed by a one-entry skid register, so a new
// request is taken while a finished result waits; the whole pipeline stalls
// only while the skid register is full. Intrinsics are written through the
// plain write port and must only change while no request is in flight.
`default_nettype none

module depth_to_color_pixel_reprojection #(
    parameter int COLOR_WIDTH  = dcpr_pkg::COLOR_WIDTH_DEF,
    parameter int COLOR_HEIGHT = dcpr_pkg::COLOR_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dcpr_pkg::IDX_W-1:0]       cfg_index,
    input  logic [dcpr_pkg::REG_W-1:0]       cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  dcpr_pkg::pix_t                   pix,
    output logic                             res_valid,
    input  logic                             res_ready,
    output dcpr_pkg::res_t                   res
);

    localparam int ACC_W = 62;
    localparam logic signed [ACC_W-1:0] P_HI = (ACC_W'(1) <<< 40) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] P_LO = -P_HI;
    localparam logic signed [23:0] U_LIM = 24'(COLOR_WIDTH * 256);
    localparam logic signed [23:0] V_LIM = 24'(COLOR_HEIGHT * 256);

    // Configuration registers.
    logic [dcpr_pkg::REG_W-1:0] cfg_reg [dcpr_pkg::REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcpr_pkg::REG_COUNT; i++)
            begin
                cfg_reg[i] <= dcpr_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic [19:0] dfx, dfy, dcx, dcy, cfx, cfy, ccx, ccy;
    assign dfx = cfg_reg[dcpr_pkg::REG_DEPTH_FX];
    assign dfy = cfg_reg[dcpr_pkg::REG_DEPTH_FY];
    assign dcx = cfg_reg[dcpr_pkg::REG_DEPTH_CX];
    assign dcy = cfg_reg[dcpr_pkg::REG_DEPTH_CY];
    assign cfx = cfg_reg[dcpr_pkg::REG_COLOR_FX];
    assign cfy = cfg_reg[dcpr_pkg::REG_COLOR_FY];
    assign ccx = cfg_reg[dcpr_pkg::REG_COLOR_CX];
    assign ccy = cfg_reg[dcpr_pkg::REG_COLOR_CY];

    // Global advance: the pipeline moves unless the skid register is occupied.
    logic en;
    logic skid_valid_reg;
    assign en        = !skid_valid_reg;
    assign pix_ready = en;

    // Stage A: pixel offset from the depth principal point, as sign and magnitude.
    logic signed [20:0] dux, duy;
    logic [20:0]        nux, nuy;
    logic               a_valid_reg, a_keep_reg, a_sx_reg, a_sy_reg;
    logic [19:0]        a_mx_reg, a_my_reg;
    logic [15:0]        a_depth_reg;

    always_comb
    begin
        dux = $signed({2'b0, pix.src_col, 8'b0}) - $signed({1'b0, dcx});
        duy = $signed({2'b0, pix.src_row, 8'b0}) - $signed({1'b0, dcy});
        nux = 21'(0) - dux;
        nuy = 21'(0) - duy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sx_reg    <= dux[20];
            a_sy_reg    <= duy[20];
            a_mx_reg    <= dux[20] ? nux[19:0] : dux[19:0];
            a_my_reg    <= duy[20] ? nuy[19:0] : duy[19:0];
            a_depth_reg <= pix.depth_mm;
            a_keep_reg  <= (pix.depth_mm != 16'd0) && (dfx != 20'd0) && (dfy != 20'd0);
        end
    end

    // Stage B: offset times depth.
    logic        b_valid_reg, b_keep_reg, b_sx_reg, b_sy_reg;
    logic [35:0] b_px_reg, b_py_reg;
    logic [15:0] b_depth_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_px_reg    <= a_mx_reg * a_depth_reg;
            b_py_reg    <= a_my_reg * a_depth_reg;
            b_sx_reg    <= a_sx_reg;
            b_sy_reg    <= a_sy_reg;
            b_depth_reg <= a_depth_reg;
            b_keep_reg  <= a_keep_reg;
        end
    end

    // Back-projection division by the depth focal lengths; an overflow
    // saturates the magnitude at all ones.
    logic        dx_valid, dy_valid, dx_ovf, dy_ovf;
    logic [35:0] dx_q, dy_q;
    logic [17:0] dx_side;
    logic [0:0]  dy_side;

    dcpr_div #(.NUM_W(44), .DEN_W(20), .Q_W(36), .SIDE_W(18)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_valid_reg),
        .num({b_px_reg, 8'b0}), .den(dfx),
        .side_in({b_sx_reg, b_keep_reg, b_depth_reg}),
        .out_valid(dx_valid), .quo(dx_q), .ovf(dx_ovf), .side_out(dx_side)
    );

    dcpr_div #(.NUM_W(44), .DEN_W(20), .Q_W(36), .SIDE_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_valid_reg),
        .num({b_py_reg, 8'b0}), .den(dfy),
        .side_in(b_sy_reg),
        .out_valid(dy_valid), .quo(dy_q), .ovf(dy_ovf), .side_out(dy_side)
    );

    // Stage C: signed camera-frame point in Q.8 millimetres.
    logic [35:0]        mxc, myc;
    logic signed [36:0] c_x_next, c_y_next;
    logic signed [36:0] c_x_reg, c_y_reg;
    logic [23:0]        c_z_reg;
    logic [15:0]        c_depth_reg;
    logic               c_valid_reg, c_keep_reg;

    always_comb
    begin
        mxc      = dx_ovf ? {36{1'b1}} : dx_q;
        myc      = dy_ovf ? {36{1'b1}} : dy_q;
        c_x_next = dx_side[17] ? -$signed({1'b0, mxc}) : $signed({1'b0, mxc});
        c_y_next = dy_side[0]  ? -$signed({1'b0, myc}) : $signed({1'b0, myc});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x_reg     <= c_x_next;
            c_y_reg     <= c_y_next;
            c_z_reg     <= {dx_side[15:0], 8'b0};
            c_depth_reg <= dx_side[15:0];
            c_keep_reg  <= dx_side[16];
        end
    end

    // Stage D: rotation partial products. X and Y are cut into an unsigned low
    // part of 18 bits and a signed high part so that none of their products is
    // wider than 24 by 19 bits.
    logic signed [42:0] d_pxl_reg [3];
    logic signed [42:0] d_pxh_reg [3];
    logic signed [42:0] d_pyl_reg [3];
    logic signed [42:0] d_pyh_reg [3];
    logic signed [48:0] d_pz_reg  [3];
    logic [15:0]        d_depth_reg;
    logic               d_valid_reg, d_keep_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_pxl_reg[i] <= dcpr_pkg::ROT[i][0] * $signed({1'b0, c_x_reg[17:0]});
                d_pxh_reg[i] <= dcpr_pkg::ROT[i][0] * $signed(c_x_reg[36:18]);
                d_pyl_reg[i] <= dcpr_pkg::ROT[i][1] * $signed({1'b0, c_y_reg[17:0]});
                d_pyh_reg[i] <= dcpr_pkg::ROT[i][1] * $signed(c_y_reg[36:18]);
                d_pz_reg[i]  <= dcpr_pkg::ROT[i][2] * $signed({1'b0, c_z_reg});
            end
            d_depth_reg <= c_depth_reg;
            d_keep_reg  <= c_keep_reg;
        end
    end

    // Stage E: recombine the split products and fold in the translation (Q.30).
    logic signed [ACC_W-1:0] e_sx_reg [3];
    logic signed [ACC_W-1:0] e_sy_reg [3];
    logic signed [ACC_W-1:0] e_tz_reg [3];
    logic [15:0]             e_depth_reg;
    logic                    e_valid_reg, e_keep_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_sx_reg[i] <= (ACC_W'(d_pxh_reg[i]) <<< 18) + ACC_W'(d_pxl_reg[i]);
                e_sy_reg[i] <= (ACC_W'(d_pyh_reg[i]) <<< 18) + ACC_W'(d_pyl_reg[i]);
                e_tz_reg[i] <= ACC_W'(d_pz_reg[i]) + (ACC_W'(dcpr_pkg::TRANS[i]) <<< 24);
            end
            e_depth_reg <= d_depth_reg;
            e_keep_reg  <= d_keep_reg;
        end
    end

    // Stage F: full sum per axis.
    logic signed [ACC_W-1:0] f_acc_reg [3];
    logic [15:0]             f_depth_reg;
    logic                    f_valid_reg, f_keep_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f_acc_reg[i] <= e_sx_reg[i] + e_sy_reg[i] + e_tz_reg[i];
            end
            f_depth_reg <= e_depth_reg;
            f_keep_reg  <= e_keep_reg;
        end
    end

    // Stage G: scale to Q.16 with truncation toward zero, then clamp.
    logic signed [ACC_W-1:0] g_bias   [3];
    logic signed [ACC_W-1:0] g_biased [3];
    logic signed [ACC_W-1:0] g_sh     [3];
    logic signed [40:0]      g_p_next [3];
    logic signed [40:0]      g_p_reg  [3];
    logic [15:0]             g_depth_reg;
    logic                    g_valid_reg, g_keep_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_bias[i]   = f_acc_reg[i][ACC_W-1] ? ACC_W'(16383) : ACC_W'(0);
            g_biased[i] = f_acc_reg[i] + g_bias[i];
            g_sh[i]     = g_biased[i] >>> 14;
            if (g_sh[i] > P_HI)
            begin
                g_p_next[i] = P_HI[40:0];
            end
            else if (g_sh[i] < P_LO)
            begin
                g_p_next[i] = P_LO[40:0];
            end
            else
            begin
                g_p_next[i] = g_sh[i][40:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                g_p_reg[i] <= g_p_next[i];
            end
            g_depth_reg <= f_depth_reg;
            g_keep_reg  <= f_keep_reg;
        end
    end

    // Stage H: sign and magnitude of X and Y; the point must lie in front.
    logic [40:0] h_neg [2];
    logic [39:0] h_m_reg [2];
    logic        h_s_reg [2];
    logic [39:0] h_pz_reg;
    logic [15:0] h_depth_reg;
    logic        h_valid_reg, h_keep_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            h_neg[i] = 41'(0) - g_p_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                h_s_reg[i] <= g_p_reg[i][40];
                h_m_reg[i] <= g_p_reg[i][40] ? h_neg[i][39:0] : g_p_reg[i][39:0];
            end
            h_pz_reg    <= g_p_reg[2][39:0];
            h_depth_reg <= g_depth_reg;
            h_keep_reg  <= g_keep_reg && !g_p_reg[2][40] && (g_p_reg[2] != 41'sd0);
        end
    end

    // Stage I: colour focal length times magnitude, in two 20 by 20 halves.
    logic [39:0] i_ul_reg, i_uh_reg, i_vl_reg, i_vh_reg;
    logic [39:0] i_pz_reg;
    logic        i_su_reg, i_sv_reg;
    logic [15:0] i_depth_reg;
    logic        i_valid_reg, i_keep_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_ul_reg    <= cfx * h_m_reg[0][19:0];
            i_uh_reg    <= cfx * h_m_reg[0][39:20];
            i_vl_reg    <= cfy * h_m_reg[1][19:0];
            i_vh_reg    <= cfy * h_m_reg[1][39:20];
            i_su_reg    <= h_s_reg[0];
            i_sv_reg    <= h_s_reg[1];
            i_pz_reg    <= h_pz_reg;
            i_depth_reg <= h_depth_reg;
            i_keep_reg  <= h_keep_reg;
        end
    end

    // Stage J: full projection numerators.
    logic [59:0] j_nu_reg, j_nv_reg;
    logic [39:0] j_pz_reg;
    logic        j_su_reg, j_sv_reg;
    logic [15:0] j_depth_reg;
    logic        j_valid_reg, j_keep_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_nu_reg    <= 60'(i_ul_reg) + {i_uh_reg, 20'b0};
            j_nv_reg    <= 60'(i_vl_reg) + {i_vh_reg, 20'b0};
            j_pz_reg    <= i_pz_reg;
            j_su_reg    <= i_su_reg;
            j_sv_reg    <= i_sv_reg;
            j_depth_reg <= i_depth_reg;
            j_keep_reg  <= i_keep_reg;
        end
    end

    // Projection division by depth. Any quotient of 2^22 or more in magnitude
    // lands outside every allowed frame, so only 22 quotient bits are formed.
    logic        du_valid, dv_valid, du_ovf, dv_ovf;
    logic [21:0] du_q, dv_q;
    logic [17:0] du_side;
    logic [0:0]  dv_side;

    dcpr_div #(.NUM_W(60), .DEN_W(40), .Q_W(22), .SIDE_W(18)) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(j_valid_reg),
        .num(j_nu_reg), .den(j_pz_reg),
        .side_in({j_su_reg, j_keep_reg, j_depth_reg}),
        .out_valid(du_valid), .quo(du_q), .ovf(du_ovf), .side_out(du_side)
    );

    dcpr_div #(.NUM_W(60), .DEN_W(40), .Q_W(22), .SIDE_W(1)) u_div_v (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(j_valid_reg),
        .num(j_nv_reg), .den(j_pz_reg),
        .side_in(j_sv_reg),
        .out_valid(dv_valid), .quo(dv_q), .ovf(dv_ovf), .side_out(dv_side)
    );

    // Stage K: signed quotient plus principal point plus one half pixel.
    logic signed [22:0] k_qu, k_qv;
    logic signed [23:0] k_tu_reg, k_tv_reg;
    logic [15:0]        k_depth_reg;
    logic               k_valid_reg, k_keep_reg;

    always_comb
    begin
        k_qu = du_side[17] ? -$signed({1'b0, du_q}) : $signed({1'b0, du_q});
        k_qv = dv_side[0]  ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_tu_reg    <= 24'(k_qu) + $signed({4'b0, ccx}) + 24'sd128;
            k_tv_reg    <= 24'(k_qv) + $signed({4'b0, ccy}) + 24'sd128;
            k_depth_reg <= du_side[15:0];
            k_keep_reg  <= du_side[16] && !du_ovf && !dv_ovf;
        end
    end

    // Stage L: truncation toward zero and frame test. Sums between -255 and
    // -1 still truncate to pixel zero.
    logic           l_in_u, l_in_v;
    logic           l_valid_reg;
    dcpr_pkg::res_t l_res_reg;

    always_comb
    begin
        l_in_u = (k_tu_reg > -24'sd256) && (k_tu_reg < U_LIM);
        l_in_v = (k_tv_reg > -24'sd256) && (k_tv_reg < V_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_res_reg.dst_col   <= k_tu_reg[23] ? 11'd0 : k_tu_reg[18:8];
            l_res_reg.dst_row   <= k_tv_reg[23] ? 10'd0 : k_tv_reg[17:8];
            l_res_reg.dst_depth <= k_depth_reg;
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pix_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= dx_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= du_valid;
            l_valid_reg <= k_valid_reg && k_keep_reg && l_in_u && l_in_v;
        end
    end

    // Output register with a skid register behind it. The skid register only
    // fills when a result leaves the pipeline while the output is held.
    logic           out_valid_reg, out_valid_next, skid_valid_next;
    logic           out_load, skid_load, push, pop;
    dcpr_pkg::res_t out_res_reg, skid_res_reg, out_res_next;

    always_comb
    begin
        push            = en && l_valid_reg;
        pop             = out_valid_reg && res_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_res_next    = l_res_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_load        = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_load       = 1'b1;
            out_valid_next = push;
        end
        else if (push)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= out_res_next;
        end
        if (skid_load)
        begin
            skid_res_reg <= l_res_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

`ifndef SYNTHESIS
    // Paired dividers run in lockstep.
    a_div_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
        (dx_valid == dy_valid) && (du_valid == dv_valid))
        else $error("paired dividers out of step");

    // The skid register is only ever occupied behind a full output register.
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A held skid entry moves to the output as soon as the output is taken.
    a_skid_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && res_ready) |=> (res_valid && !skid_valid_reg))
        else $error("skid entry not drained");

    // Every result lies inside the colour frame and carries a measurement.
    a_res_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.dst_col < COLOR_WIDTH) && (res.dst_row < COLOR_HEIGHT)
                       && (res.dst_depth != 16'd0)))
        else $error("result outside colour frame");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_depth_to_color_pixel_reprojection.sv
// Self-checking testbench for the depth-to-colour pixel reprojection block.
// Predicts every target pixel in fixed point and checks it against the block.
// Depends on dcpr_pkg and on the RTL of depth_to_color_pixel_reprojection.
`timescale 1ns / 1ps

module tb_depth_to_color_pixel_reprojection;

    localparam int  PIPE_DRAIN  = 120;
    localparam int  STALL_LIMIT = 5000;
    localparam longint XY_LIM = 64'sd68719476735;
    localparam longint P_LIM  = 64'sd1099511627775;

    typedef logic [dcpr_pkg::REG_W-1:0] reg_word_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [dcpr_pkg::IDX_W-1:0]   cfg_index;
    logic [dcpr_pkg::REG_W-1:0]   cfg_data;
    logic                         pix_valid;
    logic                         pix_ready;
    dcpr_pkg::pix_t               pix;
    logic                         res_valid;
    logic                         res_ready;
    dcpr_pkg::res_t               res;

    // The testbench's own copy of the intrinsics.
    logic [dcpr_pkg::REG_W-1:0] intrinsics [dcpr_pkg::REG_COUNT];

    // Target pixels still awaited from the block, oldest first.
    dcpr_pkg::res_t pending_targets [$];

    int  mismatches;
    int  requests_sent;
    int  targets_seen;
    int  idle_cycles;
    bit  quiet_phase;
    bit  timed_out;

    depth_to_color_pixel_reprojection DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Back-projects one image coordinate to signed Q.8 millimetres.
    function automatic longint unproject(longint coord, longint center,
                                         longint focal, longint depth);
        longint num;
        num = (coord * 256 - center) * depth * 256;
        return clamp_to(num / focal, XY_LIM);
    endfunction

    // Works out the colour-image pixel for one depth pixel; returns 0 when the
    // block is to drop it.
    function automatic bit reproject(input dcpr_pkg::pix_t p, output dcpr_pkg::res_t t);
        longint v [3];
        longint pt [3];
        longint acc;
        longint uc;
        longint vc;
        t = '0;
        if (p.depth_mm == 0) return 0;
        if (intrinsics[dcpr_pkg::REG_DEPTH_FX] == 0 || intrinsics[dcpr_pkg::REG_DEPTH_FY] == 0)
            return 0;
        v[0] = unproject(p.src_col, intrinsics[dcpr_pkg::REG_DEPTH_CX],
                         intrinsics[dcpr_pkg::REG_DEPTH_FX], p.depth_mm);
        v[1] = unproject(p.src_row, intrinsics[dcpr_pkg::REG_DEPTH_CY],
                         intrinsics[dcpr_pkg::REG_DEPTH_FY], p.depth_mm);
        v[2] = longint'(p.depth_mm) * 256;
        for (int i = 0; i < 3; i++)
        begin
            acc = longint'(dcpr_pkg::TRANS[i]) * 16777216;
            for (int j = 0; j < 3; j++)
                acc += longint'(dcpr_pkg::ROT[i][j]) * v[j];
            pt[i] = clamp_to(acc / 16384, P_LIM);
        end
        if (pt[2] <= 0) return 0;
        // Adding one half and truncating toward zero lets values just below
        // zero land on the first column or row.
        uc = ((longint'(intrinsics[dcpr_pkg::REG_COLOR_FX]) * pt[0]) / pt[2]
              + longint'(intrinsics[dcpr_pkg::REG_COLOR_CX]) + 128) / 256;
        vc = ((longint'(intrinsics[dcpr_pkg::REG_COLOR_FY]) * pt[1]) / pt[2]
              + longint'(intrinsics[dcpr_pkg::REG_COLOR_CY]) + 128) / 256;
        if (uc < 0 || uc >= dcpr_pkg::COLOR_WIDTH_DEF || vc < 0
            || vc >= dcpr_pkg::COLOR_HEIGHT_DEF) return 0;
        t.dst_col   = uc[10:0];
        t.dst_row   = vc[9:0];
        t.dst_depth = p.depth_mm;
        return 1;
    endfunction

    // One register write, then the write port is left quiet before the task returns.
    task automatic write_intrinsic(dcpr_pkg::cfg_idx_t idx, reg_word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        intrinsics[idx] = value;
        @(posedge clk);
    endtask

    // Random gaps between requests, none in the quiet phase.
    task automatic sender_gap();
        int n;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            n = int'($urandom_range(1, 5));
            repeat (n) @(posedge clk);
        end
    endtask

    // Offers one request and holds it until the block accepts it. When a
    // typed-in target is given it must agree with the predictor.
    task automatic send_pixel(dcpr_pkg::pix_t p, bit typed, bit typed_hit,
                              dcpr_pkg::res_t typed_t);
        dcpr_pkg::res_t t;
        bit             hit;
        bit             taken;
        sender_gap();
        pix_valid <= 1'b1;
        pix       <= p;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = pix_ready;
            @(posedge clk);
        end
        requests_sent++;
        hit = reproject(p, t);
        if (typed && (hit != typed_hit || (hit && t != typed_t)))
        begin
            $error("typed row: hit exp %0d act %0d, target exp %h act %h",
                   typed_hit, hit, typed_t, t);
            mismatches++;
        end
        if (hit) pending_targets.insert(pending_targets.size(), t);
    endtask

    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (pending_targets.size() != 0 && !timed_out) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Receiver side: random stalls and checking of each accepted target.
    initial
    begin
        dcpr_pkg::res_t exp_t;
        int             n;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                n = int'($urandom_range(1, 5));
                repeat (n) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(negedge clk);
            if (res_valid)
            begin
                targets_seen++;
                if (pending_targets.size() == 0)
                begin
                    $error("unexpected target col %0d row %0d", res.dst_col, res.dst_row);
                    mismatches++;
                end
                else
                begin
                    exp_t = pending_targets.pop_front();
                    if (res.dst_col != exp_t.dst_col)
                    begin
                        $error("dst_col exp %0d act %0d", exp_t.dst_col, res.dst_col);
                        mismatches++;
                    end
                    if (res.dst_row != exp_t.dst_row)
                    begin
                        $error("dst_row exp %0d act %0d", exp_t.dst_row, res.dst_row);
                        mismatches++;
                    end
                    if (res.dst_depth != exp_t.dst_depth)
                    begin
                        $error("dst_depth exp %0d act %0d", exp_t.dst_depth, res.dst_depth);
                        mismatches++;
                    end
                end
            end
            @(posedge clk);
        end
    end

    // Watchdog: ends the run after too long a spell without any handshake.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we)
                idle_cycles = 0;
            else if (++idle_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
                $display("tb_depth_to_color_pixel_reprojection: errors");
                $finish;
            end
        end
    end

    typedef struct {
        dcpr_pkg::pix_t p;
        bit             typed;
        bit             hit;
        dcpr_pkg::res_t t;
    } stim_row_t;

    // Random pixel; mostly plausible depths so that most requests land.
    function automatic dcpr_pkg::pix_t random_pixel();
        dcpr_pkg::pix_t p;
        p.src_col  = 11'($urandom_range(0, 2047));
        p.src_row  = 11'($urandom_range(0, 2047));
        case ($urandom_range(0, 9))
            0:       p.depth_mm = 16'($urandom_range(0, 65535));
            1:       p.depth_mm = 16'd0;
            default: p.depth_mm = 16'($urandom_range(200, 8000));
        endcase
        if ($urandom_range(0, 2) != 0)
        begin
            p.src_col = 11'($urandom_range(0, 1279));
            p.src_row = 11'($urandom_range(0, 719));
        end
        return p;
    endfunction

    task automatic random_intrinsics();
        for (int i = 0; i < dcpr_pkg::REG_COUNT; i++)
            write_intrinsic(dcpr_pkg::cfg_idx_t'(i),
                            (i % 4 < 2) ? reg_word_t'($urandom_range(40000, 400000))
                                        : reg_word_t'($urandom_range(0, 400000)));
    endtask

    initial
    begin
        stim_row_t      rows [$];
        dcpr_pkg::res_t none_t;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pix_valid   = 1'b0;
        pix         = '0;
        rst_n       = 1'b0;
        mismatches  = 0;
        requests_sent = 0;
        targets_seen  = 0;
        quiet_phase = 1'b0;
        timed_out   = 1'b0;
        none_t      = '0;
        for (int i = 0; i < dcpr_pkg::REG_COUNT; i++) intrinsics[i] = dcpr_pkg::CFG_RESET[i];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset intrinsics. Zero depth never lands;
        // the rest go to the predictor.
        rows.insert(rows.size(), '{'{11'd640, 11'd360, 16'd0}, 1, 0, none_t});
        rows.insert(rows.size(), '{'{11'd2047, 11'd2047, 16'd0}, 1, 0, none_t});
        rows.insert(rows.size(), '{'{11'd640, 11'd360, 16'd1000}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd0, 11'd0, 16'd1}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd0, 11'd0, 16'd65535}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd1279, 11'd719, 16'd65535}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd2047, 11'd2047, 16'd65535}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd2047, 11'd0, 16'd1}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd0, 11'd719, 16'd500}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd1279, 11'd0, 16'd500}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd640, 11'd360, 16'd2}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd1, 11'd1, 16'd300}, 0, 0, none_t});
        rows.insert(rows.size(), '{'{11'd1278, 11'd718, 16'd300}, 0, 0, none_t});
        foreach (rows[i]) send_pixel(rows[i].p, rows[i].typed, rows[i].hit, rows[i].t);
        wait_idle();

        // Zero depth focal length drops every request.
        write_intrinsic(dcpr_pkg::REG_DEPTH_FX, '0);
        send_pixel('{11'd640, 11'd360, 16'd1000}, 1, 0, none_t);
        wait_idle();
        write_intrinsic(dcpr_pkg::REG_DEPTH_FX, dcpr_pkg::CFG_RESET[dcpr_pkg::REG_DEPTH_FX]);
        write_intrinsic(dcpr_pkg::REG_DEPTH_FY, '0);
        send_pixel('{11'd640, 11'd360, 16'd1000}, 1, 0, none_t);
        wait_idle();

        // Extremes: all intrinsics at full scale, then tiny focal lengths.
        for (int i = 0; i < dcpr_pkg::REG_COUNT; i++)
            write_intrinsic(dcpr_pkg::cfg_idx_t'(i), '1);
        repeat (20) send_pixel(random_pixel(), 0, 0, none_t);
        wait_idle();
        for (int i = 0; i < dcpr_pkg::REG_COUNT; i++)
            write_intrinsic(dcpr_pkg::cfg_idx_t'(i), (i % 4 < 2) ? 20'd1 : 20'd0);
        repeat (20) send_pixel(random_pixel(), 0, 0, none_t);
        wait_idle();

        // Random phases, each with fresh intrinsics, reset values first.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 0)
                for (int i = 0; i < dcpr_pkg::REG_COUNT; i++)
                    write_intrinsic(dcpr_pkg::cfg_idx_t'(i), dcpr_pkg::CFG_RESET[i]);
            else
                random_intrinsics();
            if (ph == 5) quiet_phase = 1'b1;
            repeat (105) send_pixel(random_pixel(), 0, 0, none_t);
            wait_idle();
        end

        $display("Covered directed corners, zero focal lengths, full-scale and tiny intrinsics");
        $display("and six random phases: %0d depth pixels sent, %0d targets checked.",
                 requests_sent, targets_seen);
        if (mismatches == 0 && pending_targets.size() == 0)
            $display("tb_depth_to_color_pixel_reprojection: clean");
        else
            $display("tb_depth_to_color_pixel_reprojection: errors");
        $finish;
    end

endmodule
